[design/mlfr_pkg.sv]
// ----------------------------------------------------------------------------
// mlfr_pkg - shared definitions for the magic length frame receiver
// Widths, register indexes, codes and the control/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package mlfr_pkg;

    // payload buffer size and derived widths
    localparam int MAX_PAYLOAD = 64;
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int FILL_W      = $clog2(MAX_PAYLOAD + 1);

    // field widths
    localparam int BYTE_W     = 8;
    localparam int TIME_W     = 32;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_SECOND = 2'd2;

    // register reset values
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET      = 16'd5;
    localparam logic [BYTE_W-1:0]    MAGIC_FIRST_RESET  = 8'hCC;
    localparam logic [BYTE_W-1:0]    MAGIC_SECOND_RESET = 8'h33;

    // input operation codes
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_RESET = 1'b1;

    // result kinds
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic eval;
        logic rd_issue;
        logic rd_load;
    } mlfr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic reset_op;
        logic frame_done;
        logic out_free;
        logic rd_last;
    } mlfr_status_t;

endpackage

[design/mlfr_if.sv]
// ----------------------------------------------------------------------------
// mlfr_if - stream channels of the magic length frame receiver
// Input channel carries received bytes or reset requests, output channel
// carries verdicts and delivered payload bytes.
// ----------------------------------------------------------------------------
interface mlfr_in_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [mlfr_pkg::BYTE_W-1:0]   rx_byte;
    logic [mlfr_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, output op, output rx_byte, output now_ms, input ready);
    modport sink   (input valid, input op, input rx_byte, input now_ms, output ready);
endinterface

interface mlfr_out_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic                          consumed;
    logic [mlfr_pkg::BYTE_W-1:0]   payload_byte;
    logic [mlfr_pkg::BYTE_W-1:0]   frame_length;
    logic                          last;

    modport source (output valid, output kind, output consumed, output payload_byte,
                    output frame_length, output last, input ready);
    modport sink   (input valid, input kind, input consumed, input payload_byte,
                    input frame_length, input last, output ready);
endinterface

[design/mlfr_datapath.sv]
// ----------------------------------------------------------------------------
// mlfr_datapath - parse state, payload buffer and result register
// Holds the configuration, judges one captured byte per eval command, fills
// the payload buffer and reads it back one entry per readout step.
// ----------------------------------------------------------------------------
module mlfr_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    // captured input fields
    input  logic                                in_op,
    input  logic [mlfr_pkg::BYTE_W-1:0]         in_rx_byte,
    input  logic [mlfr_pkg::TIME_W-1:0]         in_now_ms,
    // result register
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                out_kind,
    output logic                                out_consumed,
    output logic [mlfr_pkg::BYTE_W-1:0]         out_payload_byte,
    output logic [mlfr_pkg::BYTE_W-1:0]         out_frame_length,
    output logic                                out_last,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [mlfr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mlfr_pkg::CFG_DATA_W-1:0]     cfg_data,
    // controller link
    input  mlfr_pkg::mlfr_cmd_t                 cmd,
    output mlfr_pkg::mlfr_status_t              st
);

    typedef enum logic [2:0] {
        P_IDLE    = 3'd0,
        P_MAGIC   = 3'd1,
        P_LEN     = 3'd2,
        P_PAYLOAD = 3'd3,
        P_DISCARD = 3'd4
    } parse_t;

    // captured item
    logic                               op_reg;
    logic [mlfr_pkg::BYTE_W-1:0]        byte_reg;
    logic [mlfr_pkg::TIME_W-1:0]        now_reg;

    // configuration
    logic [mlfr_pkg::TIMEOUT_W-1:0]     timeout_ms_reg;
    logic [mlfr_pkg::BYTE_W-1:0]        magic_first_reg;
    logic [mlfr_pkg::BYTE_W-1:0]        magic_second_reg;

    // parser state
    parse_t                             parse_reg;
    parse_t                             parse_next;
    parse_t                             eff_state;
    logic [mlfr_pkg::BYTE_W-1:0]        len_reg;
    logic [mlfr_pkg::BYTE_W-1:0]        len_next;
    logic [mlfr_pkg::FILL_W-1:0]        fill_reg;
    logic [mlfr_pkg::FILL_W-1:0]        fill_next;
    logic [mlfr_pkg::FILL_W-1:0]        fill_inc;
    logic [mlfr_pkg::TIME_W-1:0]        last_arrival_reg;
    logic [mlfr_pkg::TIME_W-1:0]        gap;
    logic                               timed_out;
    logic                               consumed;
    logic                               frame_done;
    logic                               store_we;

    // payload buffer and readout
    logic [mlfr_pkg::BYTE_W-1:0]        store_mem [mlfr_pkg::MAX_PAYLOAD];
    logic [mlfr_pkg::BYTE_W-1:0]        rd_data_reg;
    logic [mlfr_pkg::ADDR_W-1:0]        rd_idx_reg;
    logic                               rd_last;

    // result register
    logic                               out_valid_reg;
    logic                               out_kind_reg;
    logic                               out_consumed_reg;
    logic [mlfr_pkg::BYTE_W-1:0]        out_payload_reg;
    logic [mlfr_pkg::BYTE_W-1:0]        out_length_reg;
    logic                               out_last_reg;
    logic                               out_free;
    logic                               load_verdict;

    // capture of the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= in_op;
            byte_reg <= in_rx_byte;
            now_reg  <= in_now_ms;
        end
    end

    // configuration registers, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ms_reg   <= mlfr_pkg::TIMEOUT_RESET;
            magic_first_reg  <= mlfr_pkg::MAGIC_FIRST_RESET;
            magic_second_reg <= mlfr_pkg::MAGIC_SECOND_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mlfr_pkg::REG_TIMEOUT_MS:   timeout_ms_reg   <= cfg_data;
                mlfr_pkg::REG_MAGIC_FIRST:  magic_first_reg  <= cfg_data[mlfr_pkg::BYTE_W-1:0];
                mlfr_pkg::REG_MAGIC_SECOND: magic_second_reg <= cfg_data[mlfr_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // gap check, modulo 2^32
    assign gap       = now_reg - last_arrival_reg;
    assign timed_out = (parse_reg != P_IDLE) &&
                       (gap > mlfr_pkg::TIME_W'(timeout_ms_reg));
    assign eff_state = timed_out ? P_IDLE : parse_reg;
    assign fill_inc  = fill_reg + mlfr_pkg::FILL_W'(1);

    // byte judgement
    always_comb
    begin
        parse_next = eff_state;
        len_next   = len_reg;
        fill_next  = fill_reg;
        consumed   = 1'b1;
        frame_done = 1'b0;
        store_we   = 1'b0;
        unique case (eff_state)
            P_IDLE:
            begin
                consumed = (byte_reg == magic_first_reg);
                if (consumed)
                begin
                    parse_next = P_MAGIC;
                end
            end
            P_MAGIC:
            begin
                if (byte_reg == magic_second_reg)
                begin
                    parse_next = P_LEN;
                end
                else if (byte_reg == magic_first_reg)
                begin
                    parse_next = P_MAGIC;
                end
                else
                begin
                    parse_next = P_IDLE;
                end
            end
            P_LEN:
            begin
                fill_next = '0;
                len_next  = byte_reg;
                if (byte_reg == '0)
                begin
                    parse_next = P_IDLE;
                end
                else if (byte_reg > mlfr_pkg::BYTE_W'(mlfr_pkg::MAX_PAYLOAD))
                begin
                    parse_next = P_DISCARD;
                end
                else
                begin
                    parse_next = P_PAYLOAD;
                end
            end
            P_PAYLOAD:
            begin
                store_we  = 1'b1;
                fill_next = fill_inc;
                if (mlfr_pkg::BYTE_W'(fill_inc) >= len_reg)
                begin
                    frame_done = 1'b1;
                    parse_next = P_IDLE;
                end
            end
            default:
            begin
                // discard, also taken by the unused codes
                len_next = len_reg - mlfr_pkg::BYTE_W'(1);
                if (len_next == '0)
                begin
                    parse_next = P_IDLE;
                end
            end
        endcase
    end

    // parser state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_reg        <= P_IDLE;
            len_reg          <= '0;
            fill_reg         <= '0;
            last_arrival_reg <= '0;
        end
        else if (cmd.eval)
        begin
            if (op_reg == mlfr_pkg::OP_RESET)
            begin
                parse_reg <= P_IDLE;
            end
            else
            begin
                parse_reg        <= parse_next;
                len_reg          <= len_next;
                fill_reg         <= fill_next;
                last_arrival_reg <= now_reg;
            end
        end
    end

    // payload buffer write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.eval && (op_reg == mlfr_pkg::OP_BYTE) && store_we)
        begin
            store_mem[fill_reg[mlfr_pkg::ADDR_W-1:0]] <= byte_reg;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= store_mem[rd_idx_reg];
        end
    end

    // readout index
    assign rd_last = (mlfr_pkg::BYTE_W'(rd_idx_reg) + mlfr_pkg::BYTE_W'(1)) == len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
        end
        else if (cmd.eval && frame_done && (op_reg == mlfr_pkg::OP_BYTE))
        begin
            rd_idx_reg <= '0;
        end
        else if (cmd.rd_load && !rd_last)
        begin
            rd_idx_reg <= rd_idx_reg + mlfr_pkg::ADDR_W'(1);
        end
    end

    // result register
    assign out_free     = !out_valid_reg || out_ready;
    assign load_verdict = cmd.eval && (op_reg == mlfr_pkg::OP_BYTE) && !frame_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_verdict || cmd.rd_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_verdict)
        begin
            out_kind_reg     <= mlfr_pkg::KIND_VERDICT;
            out_consumed_reg <= consumed;
            out_payload_reg  <= '0;
            out_length_reg   <= '0;
            out_last_reg     <= 1'b1;
        end
        else if (cmd.rd_load)
        begin
            out_kind_reg     <= mlfr_pkg::KIND_PAYLOAD;
            out_consumed_reg <= 1'b1;
            out_payload_reg  <= rd_data_reg;
            out_length_reg   <= len_reg;
            out_last_reg     <= rd_last;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_kind         = out_kind_reg;
    assign out_consumed     = out_consumed_reg;
    assign out_payload_byte = out_payload_reg;
    assign out_frame_length = out_length_reg;
    assign out_last         = out_last_reg;

    // status to the controller
    assign st.reset_op   = (op_reg == mlfr_pkg::OP_RESET);
    assign st.frame_done = frame_done;
    assign st.out_free   = out_free;
    assign st.rd_last    = rd_last;

    // filling never runs past the announced length
    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        parse_reg == P_PAYLOAD |->
            (mlfr_pkg::BYTE_W'(fill_reg) < len_reg) &&
            (len_reg <= mlfr_pkg::BYTE_W'(mlfr_pkg::MAX_PAYLOAD)))
        else $error("payload fill index out of range");

    // discard always has bytes left to drop
    a_discard_left: assert property (@(posedge clk) disable iff (!rst_n)
        parse_reg == P_DISCARD |-> len_reg != '0)
        else $error("discard state with nothing remaining");

    // readout starts at the first buffer entry
    a_readout_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval && frame_done && (op_reg == mlfr_pkg::OP_BYTE) |=> rd_idx_reg == '0)
        else $error("readout index not cleared at frame end");

endmodule

[design/mlfr_ctrl.sv]
// ----------------------------------------------------------------------------
// mlfr_ctrl - sequencing controller of the magic length frame receiver
// Takes one item, has the datapath judge it, and for a completed frame steps
// the payload readout one buffer entry at a time.
// ----------------------------------------------------------------------------
module mlfr_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  mlfr_pkg::mlfr_status_t  st,
    output mlfr_pkg::mlfr_cmd_t     cmd
);

    typedef enum logic [1:0] {
        C_WAIT,
        C_EVAL,
        C_RD_ISSUE,
        C_RD_LOAD
    } ctrl_state_t;

    ctrl_state_t state_reg;
    logic        ready_reg;

    // commands follow the state and the datapath status
    assign cmd.capture  = ready_reg && in_valid;
    assign cmd.eval     = (state_reg == C_EVAL) &&
                          (st.reset_op || st.frame_done || st.out_free);
    assign cmd.rd_issue = (state_reg == C_RD_ISSUE);
    assign cmd.rd_load  = (state_reg == C_RD_LOAD) && st.out_free;
    assign in_ready     = ready_reg;

    // state and ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_WAIT;
            ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                C_WAIT:
                begin
                    if (in_valid)
                    begin
                        state_reg <= C_EVAL;
                        ready_reg <= 1'b0;
                    end
                end
                C_EVAL:
                begin
                    if (st.reset_op)
                    begin
                        state_reg <= C_WAIT;
                        ready_reg <= 1'b1;
                    end
                    else if (st.frame_done)
                    begin
                        state_reg <= C_RD_ISSUE;
                    end
                    else if (st.out_free)
                    begin
                        state_reg <= C_WAIT;
                        ready_reg <= 1'b1;
                    end
                end
                C_RD_ISSUE:
                begin
                    state_reg <= C_RD_LOAD;
                end
                C_RD_LOAD:
                begin
                    if (st.out_free)
                    begin
                        if (st.rd_last)
                        begin
                            state_reg <= C_WAIT;
                            ready_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= C_RD_ISSUE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= C_WAIT;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    // ready exactly while waiting for an item
    a_ready_state: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg == (state_reg == C_WAIT))
        else $error("ready out of step with controller state");

    // an accepted item is judged next
    a_capture_eval: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == C_EVAL)
        else $error("accepted item not judged");

    // final readout entry frees the input
    a_readout_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_load && st.rd_last |=> ready_reg)
        else $error("input not reopened after readout");

endmodule

[design/magic_length_frame_receiver.sv]
// ----------------------------------------------------------------------------
// magic_length_frame_receiver - byte-serial command frame parser
// Splits a received byte stream into command frames (two sync bytes, length,
// payload) and console traffic, delivering completed frame payloads.
// ----------------------------------------------------------------------------
// An item is taken, then judged in the evaluation state; an ordinary byte
// waits there while a previous verdict still blocks the output register,
// while a reset request is judged at once. The verdict sits in the output
// register and the next item is taken while it waits. The byte that
// completes a frame instead starts the payload readout: each buffered byte
// takes a registered buffer read, then a load of the output register once
// that register is free. Configuration may be written whenever the input is
// ready and all results have been taken.
module magic_length_frame_receiver (
    input  logic                                clk,
    input  logic                                rst_n,
    mlfr_in_if.sink                             in_ch,
    mlfr_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [mlfr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mlfr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    mlfr_pkg::mlfr_cmd_t    cmd;
    mlfr_pkg::mlfr_status_t st;
    logic                   in_ready;

    assign in_ch.ready = in_ready;

    // sequencing
    mlfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // parsing, buffering and results
    mlfr_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_op            (in_ch.op),
        .in_rx_byte       (in_ch.rx_byte),
        .in_now_ms        (in_ch.now_ms),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .out_kind         (out_ch.kind),
        .out_consumed     (out_ch.consumed),
        .out_payload_byte (out_ch.payload_byte),
        .out_frame_length (out_ch.frame_length),
        .out_last         (out_ch.last),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .st               (st)
    );

endmodule
